@@ rtl/core/ffca_pkg.sv @@
package ffca_pkg;

  // Heap geometry
  localparam int HEAP_BYTES  = 65536;
  localparam int CHUNK_BYTES = 8;
  localparam int NCHUNKS     = HEAP_BYTES / CHUNK_BYTES;
  // Chunk size is a power of two: byte and chunk indexes differ by a shift
  localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int IDX_W       = $clog2(NCHUNKS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int MARK_W      = 2;

  // Chunk marks: bit 0 free, bit 1 start of allocation
  localparam logic [MARK_W-1:0] MARK_NONE  = 2'b00;
  localparam logic [MARK_W-1:0] MARK_FREE  = 2'b01;
  localparam logic [MARK_W-1:0] MARK_START = 2'b10;
  localparam int MARK_FREE_BIT  = 0;
  localparam int MARK_START_BIT = 1;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_ALLOC_OK   = 2'd0;
  localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] ST_FREE_DONE  = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [16:0] req_bytes;
    logic [15:0] free_offset;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] alloc_offset;
  } rsp_item_t;

  // Mark store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [MARK_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

@@ rtl/core/ffca_ram.sv @@
module ffca_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/ffca_ctrl.sv @@
module ffca_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  ffca_pkg::req_item_t       req_item,
  output logic                      res_valid,
  input  logic                      res_ready,
  output ffca_pkg::rsp_item_t       res_item,
  output ffca_pkg::mem_req_t        mem,
  input  logic [ffca_pkg::MARK_W-1:0] rdata
);
  import ffca_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ASCAN  = 3'd2;
  localparam logic [2:0] S_AMARK  = 3'd3;
  localparam logic [2:0] S_FWALK  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCHUNKS - 1);
  localparam int OFF_FULL_W = IDX_W + CHUNK_SHIFT;

  logic [2:0]        state, state_next;
  logic [IDX_W-1:0]  mark_ptr, mark_ptr_next;
  logic [IDX_W-1:0]  mark_first, mark_first_next;
  logic [IDX_W-1:0]  mark_end, mark_end_next;
  logic [CNT_W-1:0]  rd_next, rd_next_next;
  logic              rd_vld, rd_vld_next;
  logic [IDX_W-1:0]  rd_addr_q, rd_addr_q_next;
  logic [CNT_W-1:0]  need, need_next;
  logic [CNT_W-1:0]  run, run_next;
  logic [IDX_W-1:0]  run_first, run_first_next;
  logic [IDX_W-1:0]  walk_idx, walk_idx_next;
  rsp_item_t         res, res_next;

  logic              can_issue;
  logic [CNT_W-1:0]  run_inc;
  logic [IDX_W-1:0]  first_c;
  logic [17:0]       bytes_round;
  logic [15:0]       off_chunk;
  logic              alloc_bad;
  logic              free_bad;

  assign can_issue = rd_next < CNT_W'(NCHUNKS);
  assign run_inc   = run + CNT_W'(1);
  assign first_c   = (run == '0) ? rd_addr_q : run_first;
  assign bytes_round = {1'b0, req_item.req_bytes} + 18'(CHUNK_BYTES - 1);
  assign off_chunk   = req_item.free_offset >> CHUNK_SHIFT;
  assign alloc_bad = (req_item.req_bytes == '0) ||
                     (32'(req_item.req_bytes) > 32'(HEAP_BYTES));
  assign free_bad  = (32'(req_item.free_offset) >= 32'(HEAP_BYTES)) ||
                     (32'(off_chunk) >= 32'(NCHUNKS));

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_FINISH);
  assign res_item  = res;

  // Sequencer: clearing sweep, first-fit scan, run marking, free walk
  always_comb begin
    state_next      = state;
    mark_ptr_next   = mark_ptr;
    mark_first_next = mark_first;
    mark_end_next   = mark_end;
    rd_next_next    = rd_next;
    need_next       = need;
    run_next        = run;
    run_first_next  = run_first;
    walk_idx_next   = walk_idx;
    res_next        = res;
    mem             = '0;

    unique case (state)
      S_CLEAR: begin
        mem.we        = 1'b1;
        mem.waddr     = mark_ptr;
        mem.wdata     = MARK_FREE;
        mark_ptr_next = mark_ptr + IDX_W'(1);
        if (mark_ptr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          res_next.alloc_offset = '0;
          if (req_item.cmd == CMD_ALLOC) begin
            if (alloc_bad) begin
              res_next.status = ST_ALLOC_FAIL;
              state_next      = S_FINISH;
            end else begin
              need_next    = CNT_W'(bytes_round >> CHUNK_SHIFT);
              run_next     = '0;
              mem.re       = 1'b1;
              mem.raddr    = '0;
              rd_next_next = CNT_W'(1);
              state_next   = S_ASCAN;
            end
          end else begin
            res_next.status = ST_FREE_DONE;
            if (free_bad) begin
              state_next = S_FINISH;
            end else begin
              walk_idx_next = IDX_W'(off_chunk);
              mem.re        = 1'b1;
              mem.raddr     = IDX_W'(off_chunk);
              rd_next_next  = CNT_W'(off_chunk) + CNT_W'(1);
              state_next    = S_FWALK;
            end
          end
        end
      end
      S_ASCAN: begin
        if (can_issue) begin
          mem.re       = 1'b1;
          mem.raddr    = rd_next[IDX_W-1:0];
          rd_next_next = rd_next + CNT_W'(1);
        end
        if (rd_vld) begin
          if (!rdata[MARK_FREE_BIT]) begin
            run_next = '0;
          end else begin
            run_next       = run_inc;
            run_first_next = first_c;
          end
          if (rdata[MARK_FREE_BIT] && run_inc == need) begin
            // Run found: mark it taken
            mark_ptr_next         = first_c;
            mark_first_next       = first_c;
            mark_end_next         = rd_addr_q;
            res_next.status       = ST_ALLOC_OK;
            res_next.alloc_offset = 16'(OFF_FULL_W'(first_c) << CHUNK_SHIFT);
            state_next            = S_AMARK;
          end else if (rd_addr_q == LAST_IDX) begin
            res_next.status = ST_ALLOC_FAIL;
            state_next      = S_FINISH;
          end
        end
      end
      S_AMARK: begin
        mem.we        = 1'b1;
        mem.waddr     = mark_ptr;
        mem.wdata     = (mark_ptr == mark_first) ? MARK_START : MARK_NONE;
        mark_ptr_next = mark_ptr + IDX_W'(1);
        if (mark_ptr == mark_end) begin
          state_next = S_FINISH;
        end
      end
      S_FWALK: begin
        if (can_issue) begin
          mem.re       = 1'b1;
          mem.raddr    = rd_next[IDX_W-1:0];
          rd_next_next = rd_next + CNT_W'(1);
        end
        if (rd_vld) begin
          // Stop at a free chunk or at the start of the next allocation
          if (rdata[MARK_FREE_BIT] ||
              (rd_addr_q != walk_idx && rdata[MARK_START_BIT])) begin
            state_next = S_FINISH;
          end else begin
            mem.we    = 1'b1;
            mem.waddr = rd_addr_q;
            mem.wdata = rdata | MARK_FREE;
            if (rd_addr_q == LAST_IDX) begin
              state_next = S_FINISH;
            end
          end
        end
      end
      S_FINISH: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    rd_vld_next    = mem.re;
    rd_addr_q_next = mem.raddr;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      mark_ptr <= '0;
      rd_vld   <= 1'b0;
    end else begin
      state    <= state_next;
      mark_ptr <= mark_ptr_next;
      rd_vld   <= rd_vld_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    mark_first <= mark_first_next;
    mark_end   <= mark_end_next;
    rd_next    <= rd_next_next;
    rd_addr_q  <= rd_addr_q_next;
    need       <= need_next;
    run        <= run_next;
    run_first  <= run_first_next;
    walk_idx   <= walk_idx_next;
    res        <= res_next;
  end

endmodule

@@ rtl/core/first_fit_chunk_allocator.sv @@
// First-fit chunk allocator over a heap of fixed-size chunks.
//
// Request channel (req_valid/req_ready/req_item): cmd selects allocate or
// free. Allocate rounds req_bytes up to whole chunks and claims the lowest
// free run long enough; free releases chunks from free_offset up to the
// next free chunk or start of allocation. Each request gives one response
// on the response channel (rsp_valid/rsp_ready/rsp_item).
//
// One request is handled at a time; req_ready is low while it is at work.
// The chunk marks sit in one memory walked one entry per cycle with a
// pipelined read: an allocate scans the marks for a run and then marks
// each claimed chunk, and a free walks the marks from free_offset; a
// rejected request goes straight to its response.
//
// After reset a clearing pass marks every chunk free; req_ready stays low
// throughout. A stalled response is held in the output register while the
// next request is taken and processed; that request's response waits until
// the register frees up.
module first_fit_chunk_allocator (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  ffca_pkg::req_item_t   req_item,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output ffca_pkg::rsp_item_t   rsp_item
);
  import ffca_pkg::*;

  mem_req_t          mem;
  logic [MARK_W-1:0] rdata;
  logic              res_valid;
  logic              res_ready;
  rsp_item_t         res_item;

  ffca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem       (mem),
    .rdata     (rdata)
  );

  ffca_ram #(
    .WIDTH (MARK_W),
    .DEPTH (NCHUNKS)
  ) u_marks (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp_item <= res_item;
    end
  end

endmodule

@@ rtl/core/ffca_checker.sv @@
module ffca_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input ffca_pkg::req_item_t req_item,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input ffca_pkg::rsp_item_t rsp_item
);
  import ffca_pkg::*;

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("stalled response changed");

  // Drop ready after each transfer in
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_item.status == ST_ALLOC_OK ||
                   rsp_item.status == ST_ALLOC_FAIL ||
                   rsp_item.status == ST_FREE_DONE))
    else $error("unknown status code");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.status != ST_ALLOC_OK |-> rsp_item.alloc_offset == '0)
    else $error("offset set on a non-allocation response");

  a_reset_busy: assert property (@(posedge clk)
    $past(rst) |-> !req_ready && !rsp_valid)
    else $error("ready during clearing pass");

endmodule

bind first_fit_chunk_allocator ffca_checker u_ffca_checker (.*);

@@ bench/first_fit_chunk_allocator_test.sv @@
`timescale 1ns / 1ps

module first_fit_chunk_allocator_test;
  import ffca_pkg::*;

  // Slowest request: a full scan plus a full claim, with both sides stalling
  localparam int MAX_REQUESTS = 160;
  localparam int CYCLE_LIMIT  = NCHUNKS + MAX_REQUESTS * (2 * NCHUNKS + 32) * 4;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    int unsigned offset;
    int unsigned bytes;
  } live_block_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req_item = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp_item;

  // Shadow copy of the chunk marks, and outcomes still to arrive
  logic [MARK_W-1:0] heap_marks [NCHUNKS];
  rsp_item_t         pending_outcomes [$];
  live_block_t       live_blocks [$];
  rsp_item_t         oldest_outcome;
  bit                quiet = 1'b0;
  int                mismatches = 0;
  int                cycle_count = 0;

  first_fit_chunk_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

  always #5 clk = ~clk;

  // Work out the outcome of one request and update the shadow marks
  function automatic rsp_item_t heap_outcome(req_item_t item);
    rsp_item_t outcome;
    int        need;
    int        run;
    int        first;
    int        idx;
    outcome.status       = ST_FREE_DONE;
    outcome.alloc_offset = '0;
    if (item.cmd == CMD_ALLOC) begin
      outcome.status = ST_ALLOC_FAIL;
      if (item.req_bytes != 0 && int'(item.req_bytes) <= HEAP_BYTES) begin
        need = (int'(item.req_bytes) + CHUNK_BYTES - 1) / CHUNK_BYTES;
        run  = 0;
        for (int i = 0; i < NCHUNKS; i++) begin
          if (!heap_marks[i][MARK_FREE_BIT]) begin
            run = 0;
          end else begin
            run++;
            if (run == need) begin
              first = i + 1 - need;
              for (int j = first; j <= i; j++)
                heap_marks[j] = (j == first) ? MARK_START : MARK_NONE;
              outcome.status       = ST_ALLOC_OK;
              outcome.alloc_offset = 16'(first * CHUNK_BYTES);
              break;
            end
          end
        end
      end
    end else if (int'(item.free_offset) < HEAP_BYTES) begin
      idx = int'(item.free_offset) / CHUNK_BYTES;
      for (int i = idx; i < NCHUNKS; i++) begin
        if (heap_marks[i][MARK_FREE_BIT] || (i != idx && heap_marks[i][MARK_START_BIT]))
          break;
        heap_marks[i][MARK_FREE_BIT] = 1'b1;
      end
    end
    return outcome;
  endfunction

  // Present one request and hold it until the transfer; entered just after a falling edge
  task automatic send_request(input logic cmd, input int unsigned bytes,
                              input int unsigned offset);
    req_item_t   item;
    rsp_item_t   outcome;
    live_block_t blk;
    item.cmd         = cmd;
    item.req_bytes   = 17'(bytes);
    item.free_offset = 16'(offset);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    do @(posedge clk); while (!req_ready);
    outcome = heap_outcome(item);
    pending_outcomes.push_back(outcome);
    if (cmd == CMD_ALLOC && outcome.status == ST_ALLOC_OK) begin
      blk.offset = outcome.alloc_offset;
      blk.bytes  = bytes;
      live_blocks.push_back(blk);
    end
    @(negedge clk);
  endtask

  task automatic alloc_bytes(input int unsigned bytes);
    send_request(CMD_ALLOC, bytes, $urandom_range(0, 65535));
  endtask

  task automatic free_at(input int unsigned offset);
    send_request(CMD_FREE, $urandom_range(0, 131071), offset);
  endtask

  // Hold the sender back until every outcome is back
  task automatic wait_for_outcomes();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending_outcomes.size() != 0);
  endtask

  // Zero, oversize and whole-heap requests, and a full heap
  task automatic test_size_extremes();
    alloc_bytes(0);
    alloc_bytes(HEAP_BYTES + 1);
    alloc_bytes(131071);
    alloc_bytes(HEAP_BYTES);
    alloc_bytes(1);
    free_at(0);
  endtask

  // Fragmented heap with no run long enough, frees off chunk boundaries
  task automatic test_fragmentation();
    alloc_bytes(HEAP_BYTES / 2);
    alloc_bytes(HEAP_BYTES / 2);
    free_at(3);
    alloc_bytes(40000);
    free_at(HEAP_BYTES / 2);
    alloc_bytes(HEAP_BYTES);
    free_at(65535);
    free_at(0);
  endtask

  // Stale start marks, frees in the middle of a run, frees of free chunks
  task automatic test_start_marks();
    alloc_bytes(8);
    alloc_bytes(8);
    alloc_bytes(17);
    free_at(8);
    free_at(0);
    alloc_bytes(16);
    free_at(12);
    free_at(0);
    free_at(20);
    free_at(16);
    free_at(40000);
  endtask

  // Mostly well-formed allocate and free traffic, with some noise
  task automatic test_random_traffic(input int count);
    int          pick;
    int          k;
    live_block_t blk;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (n == count / 2)
        wait_for_outcomes();
      if (pick < 30 && live_blocks.size() != 0) begin
        k   = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[k];
        live_blocks.delete(k);
        case ($urandom_range(0, 5))
          0:       free_at(blk.offset + $urandom_range(1, CHUNK_BYTES - 1));
          1:       free_at(blk.offset + $urandom_range(0, blk.bytes - 1));
          default: free_at(blk.offset);
        endcase
      end else if (pick < 80) begin
        alloc_bytes($urandom_range(1, 256));
      end else if (pick < 86) begin
        alloc_bytes($urandom_range(257, HEAP_BYTES));
      end else if (pick < 93) begin
        free_at($urandom_range(0, 65535));
      end else if (pick < 96) begin
        alloc_bytes(0);
      end else begin
        alloc_bytes($urandom_range(HEAP_BYTES + 1, 131071));
      end
    end
  endtask

  // Receiver: stall in bursts, otherwise accept
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  // Compare each response transfer with the oldest outcome
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("response with nothing outstanding: status %0d alloc_offset %0d",
               rsp_item.status, rsp_item.alloc_offset);
        mismatches++;
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        if (rsp_item.status !== oldest_outcome.status) begin
          $error("status: expected %0d, got %0d", oldest_outcome.status, rsp_item.status);
          mismatches++;
        end
        if (rsp_item.alloc_offset !== oldest_outcome.alloc_offset) begin
          $error("alloc_offset: expected %0d, got %0d",
                 oldest_outcome.alloc_offset, rsp_item.alloc_offset);
          mismatches++;
        end
      end
    end
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[first_fit_chunk_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NCHUNKS; i++)
      heap_marks[i] = MARK_FREE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_size_extremes();
    test_fragmentation();
    test_start_marks();
    wait_for_outcomes();
    test_random_traffic(60);
    quiet = 1'b1;
    test_random_traffic(15);

    // Drain, then let the block settle before the verdict
    wait_for_outcomes();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0)
      $display("[first_fit_chunk_allocator] OK");
    else
      $display("[first_fit_chunk_allocator] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ffca_pkg.sv
rtl/core/ffca_ram.sv
rtl/core/ffca_ctrl.sv
rtl/core/first_fit_chunk_allocator.sv
rtl/core/ffca_checker.sv
bench/first_fit_chunk_allocator_test.sv
